FILE: rtl/stack_machine_execute_unit_assert.svh
// Assertion macros for the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SMEU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/smeu_pkg.sv
// Shared types and constants of the stack machine execute unit.
package smeu_pkg;

    localparam int STACK_DEPTH = 512;
    localparam int DATA_WIDTH  = 32;

    typedef enum logic [4:0] {
        OP_LDC     = 5'd0,
        OP_LDV     = 5'd1,
        OP_ADD     = 5'd2,
        OP_SUB     = 5'd3,
        OP_MULT    = 5'd4,
        OP_DIVI    = 5'd5,
        OP_INV     = 5'd6,
        OP_AND     = 5'd7,
        OP_OR      = 5'd8,
        OP_NEG     = 5'd9,
        OP_CME     = 5'd10,
        OP_CMA     = 5'd11,
        OP_CEQ     = 5'd12,
        OP_CDIF    = 5'd13,
        OP_CMEQ    = 5'd14,
        OP_CMAQ    = 5'd15,
        OP_STR     = 5'd16,
        OP_JMP     = 5'd17,
        OP_JMPF    = 5'd18,
        OP_RD      = 5'd19,
        OP_PRN     = 5'd20,
        OP_START   = 5'd21,
        OP_ALLOC   = 5'd22,
        OP_DALLOC  = 5'd23,
        OP_HLT     = 5'd24,
        OP_CALL    = 5'd25,
        OP_RETURN  = 5'd26,
        OP_RETURNF = 5'd27,
        OP_NOP     = 5'd28
    } t_op;

    typedef enum logic [2:0] {
        STAT_CONT  = 3'd0,
        STAT_HALT  = 3'd1,
        STAT_DIV0  = 3'd2,
        STAT_RANGE = 3'd3,
        STAT_END   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_EXEC,
        ST_DIV,
        ST_CP_RD,
        ST_CP_WR,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/smeu_ram.sv
// Generic single write port, single read port RAM with registered read.
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/smeu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smeu_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;
    logic             r_neg;

    logic [WIDTH:0]   w_rem_sh;
    logic [WIDTH:0]   w_diff;
    logic [WIDTH-1:0] w_mag_x;
    logic [WIDTH-1:0] w_mag_y;

    assign w_mag_x  = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_y  = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
    assign w_rem_sh = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_x;
            r_dvs <= w_mag_y;
            r_neg <= i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
        end else if (r_busy) begin
            if (!w_diff[WIDTH]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

FILE: rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: control, datapath and stack memory.
//
// Usage: each transfer on the s_axis channel carries one decoded instruction;
// for each one exactly one result transfer leaves on m_axis with the next
// instruction index, a status, an optional print value and the new stack top.
// The program length register is written through i_cfg_we / i_cfg_wdata; the user
// must do so while no instruction is in flight, as the unit does not enforce it.
// Instructions that do not read the stack go from decode to done; one stack
// read adds the execute state, two operands the fetch and execute states,
// division also the divide state (one quotient bit per cycle in the divider),
// and alloc/dealloc a copy read and a copy write state per word (one read and
// one write of the stack memory per word, the read data coming from the
// registered read port). One instruction is in flight at a time. The stack
// memory's single read port sets this order of states.
// After reset the unit sweeps zeros through all STACK_DEPTH words of the stack
// memory, one word per cycle, with s_axis_tready low; config writes are taken.
// A finished result is held in an output register; if the receiver stalls,
// the next instruction is still accepted and runs until its result is ready.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,     // program_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[4:0], instr_index[15:5], operand_a[47:16], operand_b[57:48],
    // read_value[89:58], zero fill
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_index[11:0], status[14:12], print_valid[15], print_value[47:16],
    // top_index[57:48], zero fill
    output logic [63:0] m_axis_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = AW + 1;
    localparam int DW = smeu_pkg::DATA_WIDTH;
    localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);

    smeu_pkg::t_state r_state, n_state;

    logic [11:0]          r_plen;
    logic [4:0]           r_func;
    logic [10:0]          r_idx;
    logic signed [DW-1:0] r_a;
    logic [9:0]           r_b;
    logic [DW-1:0]        r_rv;
    logic signed [TW-1:0] r_top;
    logic [DW-1:0]        r_x;
    logic [9:0]           r_j, n_j;
    logic [AW-1:0]        r_clr;

    logic [11:0]             r_res_next, n_res_next;
    smeu_pkg::t_status       r_res_status, n_res_status;
    logic                    r_res_pv, n_res_pv;
    logic [DW-1:0]           r_res_pval, n_res_pval;
    logic signed [TW-1:0]    r_new_top, n_new_top;
    logic                    r_wen, n_wen;
    logic [AW-1:0]           r_waddr, n_waddr;
    logic [DW-1:0]           r_wdata, n_wdata;

    logic        r_out_valid;
    logic [63:0] r_out_data;

    smeu_pkg::t_op w_op;
    logic [11:0]   w_idx_ext;
    logic [11:0]   w_idx_inc;
    logic signed [33:0] w_a, w_b, w_t, w_plen, w_a_end;
    logic w_past, w_in_a, w_in_end, w_jok, w_one, w_two, w_push_ok;
    logic w_is_bin, w_is_rd1, w_is_alloc, w_dec_err, w_cp_last;
    logic [AW-1:0] w_t_a, w_tm1, w_tp1, w_cp_src, w_cp_dst;
    logic [DW-1:0] w_rdata, w_alu, w_prod, w_quot;
    logic w_slt_xy, w_slt_yx, w_out_free, w_div_done;
    logic w_mem_we, w_div_start;
    logic [AW-1:0] w_mem_waddr, w_mem_raddr;
    logic [DW-1:0] w_mem_wdata;
    smeu_pkg::t_status w_status_final;

    // Decode and range checks
    assign w_op      = smeu_pkg::t_op'(r_func);
    assign w_idx_ext = {1'b0, r_idx};
    assign w_idx_inc = w_idx_ext + 12'd1;
    assign w_a       = 34'(r_a);
    assign w_b       = 34'(r_b);
    assign w_t       = 34'(r_top);
    assign w_plen    = 34'(r_plen);
    assign w_a_end   = w_a + w_b - 34'sd1;
    assign w_past    = w_idx_ext >= r_plen;
    assign w_in_a    = (w_a >= 0) && (w_a < DEPTH_S);
    assign w_in_end  = (w_a_end >= 0) && (w_a_end < DEPTH_S);
    assign w_jok     = (w_a >= 0) && (w_a <= w_plen);
    assign w_one     = w_t >= 0;
    assign w_two     = w_t >= 1;
    assign w_push_ok = w_t < (DEPTH_S - 34'sd1);

    assign w_is_bin = (w_op == smeu_pkg::OP_ADD) || (w_op == smeu_pkg::OP_SUB) ||
                      (w_op == smeu_pkg::OP_MULT) || (w_op == smeu_pkg::OP_DIVI) ||
                      (w_op == smeu_pkg::OP_AND) || (w_op == smeu_pkg::OP_OR) ||
                      (w_op == smeu_pkg::OP_CME) || (w_op == smeu_pkg::OP_CMA) ||
                      (w_op == smeu_pkg::OP_CEQ) || (w_op == smeu_pkg::OP_CDIF) ||
                      (w_op == smeu_pkg::OP_CMEQ) || (w_op == smeu_pkg::OP_CMAQ);
    assign w_is_rd1 = (w_op == smeu_pkg::OP_LDV) || (w_op == smeu_pkg::OP_INV) ||
                      (w_op == smeu_pkg::OP_NEG) || (w_op == smeu_pkg::OP_STR) ||
                      (w_op == smeu_pkg::OP_JMPF) || (w_op == smeu_pkg::OP_PRN) ||
                      (w_op == smeu_pkg::OP_RETURN) || (w_op == smeu_pkg::OP_RETURNF);
    assign w_is_alloc = w_op == smeu_pkg::OP_ALLOC;

    always_comb begin
        unique case (w_op)
            smeu_pkg::OP_LDC, smeu_pkg::OP_RD:  w_dec_err = !w_push_ok;
            smeu_pkg::OP_LDV:                   w_dec_err = !w_push_ok || !w_in_a;
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MULT, smeu_pkg::OP_DIVI,
            smeu_pkg::OP_AND, smeu_pkg::OP_OR, smeu_pkg::OP_CME, smeu_pkg::OP_CMA,
            smeu_pkg::OP_CEQ, smeu_pkg::OP_CDIF, smeu_pkg::OP_CMEQ,
            smeu_pkg::OP_CMAQ:                  w_dec_err = !w_two;
            smeu_pkg::OP_INV, smeu_pkg::OP_NEG, smeu_pkg::OP_JMPF, smeu_pkg::OP_PRN,
            smeu_pkg::OP_START, smeu_pkg::OP_RETURN,
            smeu_pkg::OP_RETURNF:               w_dec_err = !w_one;
            smeu_pkg::OP_STR:                   w_dec_err = !w_one || !w_in_a;
            smeu_pkg::OP_JMP:                   w_dec_err = !w_jok;
            smeu_pkg::OP_CALL:                  w_dec_err = !w_push_ok || !w_jok;
            smeu_pkg::OP_ALLOC:                 w_dec_err = (r_b != 10'd0) &&
                (!w_in_a || !w_in_end || (w_t + w_b >= DEPTH_S));
            smeu_pkg::OP_DALLOC:                w_dec_err = (r_b != 10'd0) &&
                (!w_in_a || !w_in_end || !w_one || (w_t - w_b + 34'sd1 < 0));
            default:                            w_dec_err = 1'b0;
        endcase
    end

    // Addresses
    assign w_t_a     = r_top[AW-1:0];
    assign w_tm1     = w_t_a - 1'b1;
    assign w_tp1     = w_t_a + 1'b1;
    assign w_cp_src  = w_is_alloc ? (r_a[AW-1:0] + AW'(r_j)) : (w_t_a - AW'(r_j));
    assign w_cp_dst  = w_is_alloc ? (w_tp1 + AW'(r_j))
                                  : (r_a[AW-1:0] + AW'(r_b) - AW'(1) - AW'(r_j));
    assign w_cp_last = r_j == (r_b - 10'd1);

    // Arithmetic
    assign w_slt_xy = $signed(r_x) < $signed(w_rdata);
    assign w_slt_yx = $signed(w_rdata) < $signed(r_x);
    assign w_prod   = r_x * w_rdata;

    always_comb begin
        case (w_op)
            smeu_pkg::OP_ADD:  w_alu = r_x + w_rdata;
            smeu_pkg::OP_SUB:  w_alu = r_x - w_rdata;
            smeu_pkg::OP_MULT: w_alu = w_prod;
            smeu_pkg::OP_AND:  w_alu = DW'((r_x == DW'(1)) && (w_rdata == DW'(1)));
            smeu_pkg::OP_OR:   w_alu = DW'((r_x == DW'(1)) || (w_rdata == DW'(1)));
            smeu_pkg::OP_CME:  w_alu = DW'(w_slt_xy);
            smeu_pkg::OP_CMA:  w_alu = DW'(w_slt_yx);
            smeu_pkg::OP_CEQ:  w_alu = DW'(r_x == w_rdata);
            smeu_pkg::OP_CDIF: w_alu = DW'(r_x != w_rdata);
            smeu_pkg::OP_CMEQ: w_alu = DW'(!w_slt_yx);
            smeu_pkg::OP_CMAQ: w_alu = DW'(!w_slt_xy);
            default:           w_alu = r_x;
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smeu_pkg::ST_CLEAR:  if (r_clr == AW'(STACK_DEPTH - 1)) n_state = smeu_pkg::ST_IDLE;
            smeu_pkg::ST_IDLE:   if (s_axis_tvalid) n_state = smeu_pkg::ST_DECODE;
            smeu_pkg::ST_DECODE: begin
                if (w_past || w_dec_err) begin
                    n_state = smeu_pkg::ST_DONE;
                end else if (w_is_bin) begin
                    n_state = smeu_pkg::ST_FETCH;
                end else if (w_is_rd1) begin
                    n_state = smeu_pkg::ST_EXEC;
                end else if (((w_op == smeu_pkg::OP_ALLOC) ||
                              (w_op == smeu_pkg::OP_DALLOC)) && (r_b != 10'd0)) begin
                    n_state = smeu_pkg::ST_CP_RD;
                end else begin
                    n_state = smeu_pkg::ST_DONE;
                end
            end
            smeu_pkg::ST_FETCH:  n_state = smeu_pkg::ST_EXEC;
            smeu_pkg::ST_EXEC: begin
                if ((w_op == smeu_pkg::OP_DIVI) && (w_rdata != '0)) begin
                    n_state = smeu_pkg::ST_DIV;
                end else begin
                    n_state = smeu_pkg::ST_DONE;
                end
            end
            smeu_pkg::ST_DIV:    if (w_div_done) n_state = smeu_pkg::ST_DONE;
            smeu_pkg::ST_CP_RD:  n_state = smeu_pkg::ST_CP_WR;
            smeu_pkg::ST_CP_WR:  n_state = w_cp_last ? smeu_pkg::ST_DONE : smeu_pkg::ST_CP_RD;
            smeu_pkg::ST_DONE:   if (w_out_free) n_state = smeu_pkg::ST_IDLE;
            default:             n_state = smeu_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_waddr;
        w_mem_wdata   = r_wdata;
        w_mem_raddr   = w_t_a;
        w_div_start   = 1'b0;
        unique case (r_state)
            smeu_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                w_mem_wdata = '0;
            end
            smeu_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            smeu_pkg::ST_DECODE: begin
                if (w_is_bin) begin
                    w_mem_raddr = w_tm1;
                end else if (w_op == smeu_pkg::OP_LDV) begin
                    w_mem_raddr = r_a[AW-1:0];
                end
            end
            smeu_pkg::ST_EXEC:   w_div_start = (w_op == smeu_pkg::OP_DIVI) && (w_rdata != '0);
            smeu_pkg::ST_CP_RD:  w_mem_raddr = w_cp_src;
            smeu_pkg::ST_CP_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_cp_dst;
                w_mem_wdata = w_rdata;
            end
            smeu_pkg::ST_DONE:   w_mem_we = r_wen && w_out_free;
            default: ;
        endcase
    end

    // Result datapath
    always_comb begin
        n_res_next   = r_res_next;
        n_res_status = r_res_status;
        n_res_pv     = r_res_pv;
        n_res_pval   = r_res_pval;
        n_new_top    = r_new_top;
        n_wen        = r_wen;
        n_waddr      = r_waddr;
        n_wdata      = r_wdata;
        n_j          = r_j;
        case (r_state)
            smeu_pkg::ST_DECODE: begin
                n_res_next   = w_idx_inc;
                n_res_status = smeu_pkg::STAT_CONT;
                n_res_pv     = 1'b0;
                n_res_pval   = '0;
                n_new_top    = r_top;
                n_wen        = 1'b0;
                n_waddr      = w_tp1;
                n_wdata      = r_a;
                n_j          = '0;
                if (w_past) begin
                    n_res_next   = w_idx_ext;
                    n_res_status = smeu_pkg::STAT_END;
                end else if (w_dec_err) begin
                    n_res_next   = w_idx_ext;
                    n_res_status = smeu_pkg::STAT_RANGE;
                end else begin
                    case (w_op)
                        smeu_pkg::OP_LDC: begin
                            n_wen     = 1'b1;
                            n_new_top = r_top + TW'(1);
                        end
                        smeu_pkg::OP_RD: begin
                            n_wen     = 1'b1;
                            n_wdata   = r_rv;
                            n_new_top = r_top + TW'(1);
                        end
                        smeu_pkg::OP_CALL: begin
                            n_wen      = 1'b1;
                            n_wdata    = DW'(w_idx_inc);
                            n_new_top  = r_top + TW'(1);
                            n_res_next = r_a[11:0];
                        end
                        smeu_pkg::OP_JMP:   n_res_next = r_a[11:0];
                        smeu_pkg::OP_START: n_new_top = r_top - TW'(1);
                        smeu_pkg::OP_HLT: begin
                            n_res_next   = w_idx_ext;
                            n_res_status = smeu_pkg::STAT_HALT;
                        end
                        default: ;
                    endcase
                end
            end
            smeu_pkg::ST_FETCH: ;
            smeu_pkg::ST_EXEC: begin
                if (w_is_bin) begin
                    if (w_op == smeu_pkg::OP_DIVI) begin
                        if (w_rdata == '0) begin
                            n_res_next   = w_idx_ext;
                            n_res_status = smeu_pkg::STAT_DIV0;
                        end
                    end else begin
                        n_wen     = 1'b1;
                        n_waddr   = w_tm1;
                        n_wdata   = w_alu;
                        n_new_top = r_top - TW'(1);
                    end
                end else begin
                    case (w_op)
                        smeu_pkg::OP_LDV: begin
                            n_wen     = 1'b1;
                            n_wdata   = w_rdata;
                            n_new_top = r_top + TW'(1);
                        end
                        smeu_pkg::OP_INV: begin
                            n_wen   = 1'b1;
                            n_waddr = w_t_a;
                            n_wdata = DW'(0) - w_rdata;
                        end
                        smeu_pkg::OP_NEG: begin
                            n_wen   = 1'b1;
                            n_waddr = w_t_a;
                            n_wdata = DW'(1) - w_rdata;
                        end
                        smeu_pkg::OP_STR: begin
                            n_wen     = 1'b1;
                            n_waddr   = r_a[AW-1:0];
                            n_wdata   = w_rdata;
                            n_new_top = r_top - TW'(1);
                        end
                        smeu_pkg::OP_JMPF: begin
                            if ((w_rdata == '0) && !w_jok) begin
                                n_res_next   = w_idx_ext;
                                n_res_status = smeu_pkg::STAT_RANGE;
                            end else begin
                                if (w_rdata == '0) begin
                                    n_res_next = r_a[11:0];
                                end
                                n_new_top = r_top - TW'(1);
                            end
                        end
                        smeu_pkg::OP_PRN: begin
                            n_res_pv   = 1'b1;
                            n_res_pval = w_rdata;
                            n_new_top  = r_top - TW'(1);
                        end
                        smeu_pkg::OP_RETURN, smeu_pkg::OP_RETURNF: begin
                            if (w_rdata[DW-1] || (w_rdata > DW'(r_plen))) begin
                                n_res_next   = w_idx_ext;
                                n_res_status = smeu_pkg::STAT_RANGE;
                            end else begin
                                n_res_next = w_rdata[11:0];
                                n_new_top  = r_top - TW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            smeu_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_wen     = 1'b1;
                    n_waddr   = w_tm1;
                    n_wdata   = w_quot;
                    n_new_top = r_top - TW'(1);
                end
            end
            smeu_pkg::ST_CP_WR: begin
                n_j = r_j + 10'd1;
                if (w_cp_last) begin
                    n_new_top = w_is_alloc ? (r_top + TW'(r_b)) : (r_top - TW'(r_b));
                end
            end
            default: ;
        endcase
    end

    assign w_status_final = ((r_res_status == smeu_pkg::STAT_CONT) && (r_res_next == r_plen))
                            ? smeu_pkg::STAT_END : r_res_status;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smeu_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_plen      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == smeu_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if ((r_state == smeu_pkg::ST_DONE) && w_out_free) begin
                r_top       <= r_new_top;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tdata[4:0];
            r_idx  <= s_axis_tdata[15:5];
            r_a    <= s_axis_tdata[47:16];
            r_b    <= s_axis_tdata[57:48];
            r_rv   <= s_axis_tdata[89:58];
        end
        if (r_state == smeu_pkg::ST_FETCH) begin
            r_x <= w_rdata;
        end
        r_res_next   <= n_res_next;
        r_res_status <= n_res_status;
        r_res_pv     <= n_res_pv;
        r_res_pval   <= n_res_pval;
        r_new_top    <= n_new_top;
        r_wen        <= n_wen;
        r_waddr      <= n_waddr;
        r_wdata      <= n_wdata;
        r_j          <= n_j;
        if ((r_state == smeu_pkg::ST_DONE) && w_out_free) begin
            r_out_data <= {6'd0, 10'(r_new_top), 32'(r_res_pval), r_res_pv,
                           w_status_final, r_res_next};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    smeu_ram #(
        .WIDTH(DW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_mem_waddr),
        .i_wdata(w_mem_wdata),
        .i_raddr(w_mem_raddr),
        .o_rdata(w_rdata)
    );

    smeu_div #(
        .WIDTH(DW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(r_x),
        .i_divisor (w_rdata),
        .o_done    (w_div_done),
        .o_quotient(w_quot)
    );

`include "stack_machine_execute_unit_assert.svh"

    `SMEU_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == smeu_pkg::ST_DECODE, "transfer accepted without entering decode")
    `SMEU_ASSERT_IMPLY(a_top_floor, i_clk, i_rst_n, 1'b1, r_top >= -1, "stack top below empty")
    `SMEU_ASSERT_IMPLY(a_div_state, i_clk, i_rst_n, w_div_done, r_state == smeu_pkg::ST_DIV, "divider finished outside divide state")
    `SMEU_ASSERT_IMPLY(a_idle_no_write, i_clk, i_rst_n, r_state == smeu_pkg::ST_IDLE, !w_mem_we, "stack written while idle")

endmodule
